@@ hdl/fre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fre_pkg: shared types and constants for the rectangle fill engine
// Screen geometry, command codes, state encoding, controller/datapath
// interface structs and the RGB565 palette helpers.
// ----------------------------------------------------------------------------
package fre_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;
	localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int COL_W         = $clog2(SCREEN_WIDTH);
	localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
	localparam int ADDR_W        = $clog2(PIXELS);
	localparam int PAL_DEPTH     = 256;
	localparam int CUBE_ENTRIES  = 180;

	typedef enum logic [1:0] {
		OP_FILL    = 2'd0,
		OP_OUTLINE = 2'd1,
		OP_READ    = 2'd2,
		OP_PALETTE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SIDE_TOP    = 2'd0,
		SIDE_BOTTOM = 2'd1,
		SIDE_LEFT   = 2'd2,
		SIDE_RIGHT  = 2'd3
	} side_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_START,
		ST_FILL,
		ST_RD_ADDR,
		ST_RD_MEM,
		ST_RD_PAL,
		ST_PAL_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic  load;
		logic  clear_step;
		logic  setup;
		logic  outline;
		side_t side;
		logic  start;
		logic  fill_step;
		logic  rd_addr;
		logic  rd_mem;
		logic  rd_pal;
		logic  pal_wr;
		logic  out_load;
		logic  out_read;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic empty;
		logic fill_last;
		logic out_free;
	} status_t;

	function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [15:0] c;
		c = {r[7:3], g[7:2], b[7:3]};
		return {c[7:0], c[15:8]};
	endfunction

	function automatic logic [PAL_DEPTH-1:0][15:0] palette_init();
		logic [PAL_DEPTH-1:0][15:0] t;
		int r;
		int g;
		int b;
		for (int i = 0; i < PAL_DEPTH; i++) begin
			if (i < CUBE_ENTRIES) begin
				r = (i / 30) * 51;
				g = ((i / 5) % 6) * 51;
				b = (i % 5) * 63;
				t[i] = pack565(8'(r), 8'(g), 8'(b));
			end else begin
				t[i] = '0;
			end
		end
		return t;
	endfunction

	localparam logic [PAL_DEPTH-1:0][15:0] PALETTE_INIT = palette_init();

endpackage

@@ hdl/fre_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fre_ctrl: command sequencer of the rectangle fill engine
// Accepts commands, steps the datapath through clear, fill, outline, read
// and palette write sequences and hands the result to the output register.
// ----------------------------------------------------------------------------
module fre_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        s_tuser,
	input  fre_pkg::status_t  status,
	output fre_pkg::cmd_t     cmd
);

	fre_pkg::state_t state_q;
	fre_pkg::state_t state_d;
	fre_pkg::op_t    op_q;
	fre_pkg::side_t  side_q;
	logic            more_sides;

	assign more_sides = (op_q == fre_pkg::OP_OUTLINE) && (side_q != fre_pkg::SIDE_RIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fre_pkg::ST_CLEAR;
			op_q    <= fre_pkg::OP_FILL;
			side_q  <= fre_pkg::SIDE_TOP;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				op_q   <= fre_pkg::op_t'(s_tuser);
				side_q <= fre_pkg::SIDE_TOP;
			end else if ((state_q == fre_pkg::ST_START && status.empty) ||
					(state_q == fre_pkg::ST_FILL && status.fill_last)) begin
				if (more_sides) begin
					side_q <= fre_pkg::side_t'(side_q + 2'd1);
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fre_pkg::ST_CLEAR: begin
				if (status.clear_last) begin
					state_d = fre_pkg::ST_IDLE;
				end
			end
			fre_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (fre_pkg::op_t'(s_tuser))
						fre_pkg::OP_FILL,
						fre_pkg::OP_OUTLINE: state_d = fre_pkg::ST_SETUP;
						fre_pkg::OP_READ:    state_d = fre_pkg::ST_RD_ADDR;
						default:             state_d = fre_pkg::ST_PAL_WR;
					endcase
				end
			end
			fre_pkg::ST_SETUP: state_d = fre_pkg::ST_START;
			fre_pkg::ST_START: begin
				if (!status.empty) begin
					state_d = fre_pkg::ST_FILL;
				end else if (more_sides) begin
					state_d = fre_pkg::ST_SETUP;
				end else begin
					state_d = fre_pkg::ST_FINISH;
				end
			end
			fre_pkg::ST_FILL: begin
				if (status.fill_last) begin
					state_d = more_sides ? fre_pkg::ST_SETUP : fre_pkg::ST_FINISH;
				end
			end
			fre_pkg::ST_RD_ADDR: state_d = fre_pkg::ST_RD_MEM;
			fre_pkg::ST_RD_MEM:  state_d = fre_pkg::ST_RD_PAL;
			fre_pkg::ST_RD_PAL:  state_d = fre_pkg::ST_FINISH;
			fre_pkg::ST_PAL_WR:  state_d = fre_pkg::ST_FINISH;
			fre_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_d = fre_pkg::ST_IDLE;
				end
			end
			default: state_d = fre_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		cmd.side = side_q;
		case (state_q)
			fre_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			fre_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			fre_pkg::ST_SETUP: begin
				cmd.setup   = 1'b1;
				cmd.outline = (op_q == fre_pkg::OP_OUTLINE);
			end
			fre_pkg::ST_START:   cmd.start     = 1'b1;
			fre_pkg::ST_FILL:    cmd.fill_step = 1'b1;
			fre_pkg::ST_RD_ADDR: cmd.rd_addr   = 1'b1;
			fre_pkg::ST_RD_MEM:  cmd.rd_mem    = 1'b1;
			fre_pkg::ST_RD_PAL:  cmd.rd_pal    = 1'b1;
			fre_pkg::ST_PAL_WR:  cmd.pal_wr    = 1'b1;
			fre_pkg::ST_FINISH: begin
				cmd.out_load = status.out_free;
				cmd.out_read = (op_q == fre_pkg::OP_READ);
			end
			default: cmd = '0;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fre_pkg::ST_CLEAR) |-> !s_tready)
		else $error("input accepted during frame store clear");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result loaded over a pending transfer");

	a_side_only_outline: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fre_pkg::ST_SETUP && op_q != fre_pkg::OP_OUTLINE) |->
		(side_q == fre_pkg::SIDE_TOP))
		else $error("side counter advanced for a plain fill");
`endif

endmodule

@@ hdl/fre_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fre_datapath: frame store, palette and address generation
// Holds the command fields, clips rectangles, walks the covered pixels one
// per cycle, performs pixel reads through the palette and owns the output
// register.
// ----------------------------------------------------------------------------
module fre_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [79:0]       s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,
	output logic              m_tuser,
	input  fre_pkg::cmd_t     cmd,
	output fre_pkg::status_t  status
);

	localparam logic signed [14:0] SW_S = 15'(fre_pkg::SCREEN_WIDTH);
	localparam logic signed [14:0] SH_S = 15'(fre_pkg::SCREEN_HEIGHT);
	localparam logic signed [14:0] ONE_S = 15'sd1;
	localparam logic signed [12:0] SW_13 = 13'(fre_pkg::SCREEN_WIDTH);
	localparam logic signed [12:0] SH_13 = 13'(fre_pkg::SCREEN_HEIGHT);

	logic signed [11:0] x_q;
	logic signed [11:0] y_q;
	logic signed [11:0] w_q;
	logic signed [11:0] h_q;
	logic [7:0]         colour_q;
	logic [7:0]         red_q;
	logic [7:0]         green_q;
	logic [7:0]         blue_q;

	logic [7:0]  fb_mem [fre_pkg::PIXELS];
	logic [15:0] pal_mem [fre_pkg::PAL_DEPTH];
	logic [fre_pkg::PAL_DEPTH-1:0] pal_valid_q;

	logic [fre_pkg::ADDR_W-1:0] clr_q;

	logic signed [14:0] xs, ys, ws, hs;
	logic signed [14:0] rx, ry, rw, rh;
	logic signed [14:0] xe, ye;
	logic signed [14:0] c0, c1, r0, r1;
	logic signed [14:0] cl, rl;

	logic                       empty_q;
	logic [fre_pkg::COL_W-1:0]  c0_q;
	logic [fre_pkg::COL_W-1:0]  c_last_q;
	logic [fre_pkg::ROW_W-1:0]  r0_q;
	logic [fre_pkg::ROW_W-1:0]  r_last_q;
	logic [fre_pkg::COL_W-1:0]  col_q;
	logic [fre_pkg::ROW_W-1:0]  row_q;
	logic [fre_pkg::ADDR_W-1:0] row_base_q;
	logic                       col_last;
	logic                       row_last;

	logic                       fb_we;
	logic [fre_pkg::ADDR_W-1:0] fb_waddr;
	logic [7:0]                 fb_wdata;
	logic [fre_pkg::ADDR_W-1:0] fill_addr;

	logic                       on_screen;
	logic                       on_s1;
	logic [fre_pkg::ADDR_W-1:0] rd_addr_s1;
	logic [7:0]                 pix_s2;
	logic [15:0]                pal_s3;
	logic                       pv_s3;
	logic [15:0]                pinit_s3;

	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic        m_tuser_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= s_tdata[11:0];
			y_q      <= s_tdata[23:12];
			w_q      <= s_tdata[35:24];
			h_q      <= s_tdata[47:36];
			colour_q <= s_tdata[55:48];
			red_q    <= s_tdata[63:56];
			green_q  <= s_tdata[71:64];
			blue_q   <= s_tdata[79:72];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		xs = 15'(x_q);
		ys = 15'(y_q);
		ws = 15'(w_q);
		hs = 15'(h_q);
		rx = xs;
		ry = ys;
		rw = ws;
		rh = hs;
		if (cmd.outline) begin
			case (cmd.side)
				fre_pkg::SIDE_TOP: begin
					rh = ONE_S;
				end
				fre_pkg::SIDE_BOTTOM: begin
					ry = ys + hs - ONE_S;
					rh = ONE_S;
				end
				fre_pkg::SIDE_LEFT: begin
					rw = ONE_S;
				end
				default: begin
					rx = xs + ws - ONE_S;
					rw = ONE_S;
				end
			endcase
		end
		xe = rx + rw;
		ye = ry + rh;
		c0 = (rx < 15'sd0) ? 15'sd0 : rx;
		c1 = (xe > SW_S) ? SW_S : xe;
		r0 = (ry < 15'sd0) ? 15'sd0 : ry;
		r1 = (ye > SH_S) ? SH_S : ye;
		cl = c1 - ONE_S;
		rl = r1 - ONE_S;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
		end else if (cmd.setup) begin
			empty_q <= (c1 <= c0) || (r1 <= r0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			c0_q     <= c0[fre_pkg::COL_W-1:0];
			c_last_q <= cl[fre_pkg::COL_W-1:0];
			r0_q     <= r0[fre_pkg::ROW_W-1:0];
			r_last_q <= rl[fre_pkg::ROW_W-1:0];
		end
	end

	assign col_last  = (col_q == c_last_q);
	assign row_last  = (row_q == r_last_q);
	assign fill_addr = row_base_q + fre_pkg::ADDR_W'(col_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_base_q <= fre_pkg::ADDR_W'(r0_q) * fre_pkg::ADDR_W'(fre_pkg::SCREEN_WIDTH);
			col_q      <= c0_q;
			row_q      <= r0_q;
		end else if (cmd.fill_step) begin
			if (col_last) begin
				col_q      <= c0_q;
				row_q      <= row_q + 1'b1;
				row_base_q <= row_base_q + fre_pkg::ADDR_W'(fre_pkg::SCREEN_WIDTH);
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_comb begin
		fb_we    = cmd.clear_step || cmd.fill_step;
		fb_waddr = cmd.clear_step ? clr_q : fill_addr;
		fb_wdata = cmd.clear_step ? 8'd0 : colour_q;
	end

	always_ff @(posedge clk) begin
		if (fb_we) begin
			fb_mem[fb_waddr] <= fb_wdata;
		end
	end

	assign on_screen = (x_q >= 12'sd0) && (13'(x_q) < SW_13) &&
		(y_q >= 12'sd0) && (13'(y_q) < SH_13);

	always_ff @(posedge clk) begin
		if (cmd.rd_addr) begin
			on_s1      <= on_screen;
			rd_addr_s1 <= on_screen ?
				fre_pkg::ADDR_W'(y_q[fre_pkg::ROW_W-1:0]) *
				fre_pkg::ADDR_W'(fre_pkg::SCREEN_WIDTH) +
				fre_pkg::ADDR_W'(x_q[fre_pkg::COL_W-1:0]) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_mem) begin
			pix_s2 <= fb_mem[rd_addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pal_wr) begin
			pal_mem[colour_q] <= fre_pkg::pack565(red_q, green_q, blue_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_pal) begin
			pal_s3   <= pal_mem[pix_s2];
			pv_s3    <= pal_valid_q[pix_s2];
			pinit_s3 <= fre_pkg::PALETTE_INIT[pix_s2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (cmd.pal_wr) begin
			pal_valid_q[colour_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tuser_q <= cmd.out_read && on_s1;
			m_tdata_q <= (cmd.out_read && on_s1) ? (pv_s3 ? pal_s3 : pinit_s3) : 16'd0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		status.clear_last = (clr_q == fre_pkg::ADDR_W'(fre_pkg::PIXELS - 1));
		status.empty      = empty_q;
		status.fill_last  = col_last && row_last;
		status.out_free   = !m_tvalid_q || m_tready;
	end

`ifndef NO_ASSERTIONS
	a_fill_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> (col_q <= c_last_q) && (row_q <= r_last_q))
		else $error("fill walked outside the clipped rectangle");

	a_fill_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> (fill_addr < fre_pkg::ADDR_W'(fre_pkg::PIXELS)))
		else $error("fill address beyond the frame store");

	a_offscreen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !cmd.out_read) |=> (m_tdata == 16'd0) && !m_tuser)
		else $error("non-read command produced a nonzero result");
`endif

endmodule

@@ hdl/framebuffer_rect_fill_palette_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_rect_fill_palette_engine: clipped rectangle fill engine
// Indexed 8-bit frame store with a 256-entry RGB565 palette. Fills, outlines,
// pixel reads and palette writes, one command at a time.
// ----------------------------------------------------------------------------
// After reset the engine clears the frame store one pixel per cycle, covering
// all SCREEN_WIDTH*SCREEN_HEIGHT (76800) pixels; no command is accepted
// until that pass is done. Commands then run one at a time and each yields
// one result transfer. A fill writes each on-screen pixel that it covers in
// turn, since the frame store has a single write port and takes one pixel
// per cycle; an outline runs four such passes, one per side. A pixel read
// steps through address, frame store read, palette read and result, and a
// palette write through the write and the result. The next command is
// accepted while the previous result still waits on the output.
module framebuffer_rect_fill_palette_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: x, y, width, height, colour, red, green, blue.
	input  logic [79:0] s_tdata,
	// Fields from bit 0: opcode.
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: read_colour.
	output logic [15:0] m_tdata,
	// Fields from bit 0: read_valid.
	output logic        m_tuser
);

	fre_pkg::cmd_t    cmd;
	fre_pkg::status_t status;

	fre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	fre_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

@@ tb/framebuffer_rect_fill_palette_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_rect_fill_palette_engine_tb: self-checking bench for the fill engine
// Drives fill, outline, pixel read and palette write commands over the input
// stream. A shadow frame store and palette predict each result that the
// directed table does not fix itself. The table covers clipping extremes and
// off-screen reads, and a long random phase of draw-then-read traffic
// follows. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module framebuffer_rect_fill_palette_engine_tb;

	localparam int DIR_ROWS    = 27;
	localparam int RAND_CMDS   = 1700;
	localparam int CYCLE_LIMIT = 16000000;

	typedef struct {
		fre_pkg::op_t       op;
		logic signed [11:0] x;
		logic signed [11:0] y;
		logic signed [11:0] w;
		logic signed [11:0] h;
		logic [7:0]         colour;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} draw_cmd_t;

	typedef struct {
		logic [15:0] rgb;
		logic        hit;
	} reply_t;

	typedef struct {
		draw_cmd_t cmd;
		bit        typed;
		reply_t    want;
	} dir_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;

	logic [7:0]  shadow_fb [fre_pkg::PIXELS];
	logic [15:0] shadow_pal [fre_pkg::PAL_DEPTH];
	reply_t      reply_q [$];

	int fail_count;
	int cycle_count;
	int burst_left;
	int big_fills_left;
	int n_fill, n_outline, n_read, n_hit, n_pal;
	int last_x, last_y, last_w, last_h;
	logic [7:0] last_colour;
	int unsigned rx_left;
	int unsigned rx_mode;

	framebuffer_rect_fill_palette_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic draw_cmd_t cmd_of(fre_pkg::op_t op, int x, int y, int w, int h,
			int col, int r, int g, int b);
		draw_cmd_t c;
		c.op     = op;
		c.x      = 12'(x);
		c.y      = 12'(y);
		c.w      = 12'(w);
		c.h      = 12'(h);
		c.colour = 8'(col);
		c.red    = 8'(r);
		c.green  = 8'(g);
		c.blue   = 8'(b);
		return c;
	endfunction

	function automatic logic [15:0] rgb565_swapped(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return {g[4:2], b[7:3], r[7:3], g[7:5]};
	endfunction

	task automatic paint_rect(int x, int y, int w, int h, logic [7:0] c);
		int c0, c1, r0, r1;
		c0 = (x < 0) ? 0 : x;
		c1 = (x + w > fre_pkg::SCREEN_WIDTH) ? fre_pkg::SCREEN_WIDTH : x + w;
		r0 = (y < 0) ? 0 : y;
		r1 = (y + h > fre_pkg::SCREEN_HEIGHT) ? fre_pkg::SCREEN_HEIGHT : y + h;
		if (c1 <= c0)
			return;
		for (int r = r0; r < r1; r++)
			for (int col = c0; col < c1; col++)
				shadow_fb[r * fre_pkg::SCREEN_WIDTH + col] = c;
	endtask

	task automatic run_engine_cmd(input draw_cmd_t c, output reply_t res);
		int x, y, w, h;
		x = int'(c.x);
		y = int'(c.y);
		w = int'(c.w);
		h = int'(c.h);
		res = '{16'h0000, 1'b0};
		case (c.op)
			fre_pkg::OP_FILL: begin
				n_fill++;
				paint_rect(x, y, w, h, c.colour);
			end
			fre_pkg::OP_OUTLINE: begin
				n_outline++;
				paint_rect(x, y, w, 1, c.colour);
				paint_rect(x, y + h - 1, w, 1, c.colour);
				paint_rect(x, y, 1, h, c.colour);
				paint_rect(x + w - 1, y, 1, h, c.colour);
			end
			fre_pkg::OP_READ: begin
				n_read++;
				if (x >= 0 && x < fre_pkg::SCREEN_WIDTH && y >= 0 &&
						y < fre_pkg::SCREEN_HEIGHT) begin
					n_hit++;
					res.rgb = shadow_pal[shadow_fb[y * fre_pkg::SCREEN_WIDTH + x]];
					res.hit = 1'b1;
				end
			end
			default: begin
				n_pal++;
				shadow_pal[c.colour] = rgb565_swapped(c.red, c.green, c.blue);
			end
		endcase
	endtask

	task automatic put_cmd(input draw_cmd_t c, input bit typed, input reply_t want);
		int gap;
		reply_t res;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {c.blue, c.green, c.red, c.colour, c.h, c.w, c.y, c.x};
		s_tuser  <= c.op;
		do @(posedge clk); while (!s_tready);
		run_engine_cmd(c, res);
		reply_q.push_back(typed ? want : res);
	endtask

	task automatic gen_random_cmd(output draw_cmd_t c);
		int pick, sel;
		pick = $urandom_range(0, 99);
		c = cmd_of(fre_pkg::OP_FILL, 0, 0, 0, 0, $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		if (big_fills_left > 0 && $urandom_range(0, 499) == 0) begin
			big_fills_left--;
			c.x = 12'($urandom_range(0, 40) - 20);
			c.y = 12'($urandom_range(0, 40) - 20);
			c.w = 12'($urandom_range(300, 2047));
			c.h = 12'($urandom_range(220, 2047));
		end else if (pick < 30 || (pick >= 38 && pick < 44)) begin
			c.op = (pick < 30) ? fre_pkg::OP_FILL : fre_pkg::OP_OUTLINE;
			last_x = $urandom_range(0, 340) - 10;
			last_y = $urandom_range(0, 260) - 10;
			last_w = $urandom_range(0, 28) - 4;
			last_h = $urandom_range(0, 28) - 4;
			last_colour = c.colour;
			c.x = 12'(last_x);
			c.y = 12'(last_y);
			c.w = 12'(last_w);
			c.h = 12'(last_h);
		end else if (pick < 38) begin
			c.x = 12'($urandom);
			c.y = 12'($urandom);
			if ($urandom_range(0, 1) == 1) begin
				c.w = 12'($urandom);
				c.h = 12'($urandom_range(0, 9) - 3);
			end else begin
				c.w = 12'($urandom_range(0, 9) - 3);
				c.h = 12'($urandom);
			end
		end else if (pick < 50) begin
			// An outline never covers more than its four clipped edges.
			c.op = fre_pkg::OP_OUTLINE;
			c.x  = 12'($urandom);
			c.y  = 12'($urandom);
			c.w  = 12'($urandom);
			c.h  = 12'($urandom);
		end else if (pick < 80) begin
			c.op = fre_pkg::OP_READ;
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				c.x = 12'(last_x + $urandom_range(0, (last_w > 1) ? last_w - 1 : 0));
				c.y = 12'(last_y + $urandom_range(0, (last_h > 1) ? last_h - 1 : 0));
			end else if (sel < 85) begin
				c.x = 12'($urandom_range(0, fre_pkg::SCREEN_WIDTH - 1));
				c.y = 12'($urandom_range(0, fre_pkg::SCREEN_HEIGHT - 1));
			end else begin
				c.x = 12'($urandom);
				c.y = 12'($urandom);
			end
		end else begin
			c.op = fre_pkg::OP_PALETTE;
			if ($urandom_range(0, 1) == 1)
				c.colour = last_colour;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_left  <= 0;
			rx_mode  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 20)
						$display("%0t: expected no transfer, got rgb %h valid %b",
							$time, m_tdata, m_tuser);
				end else if (m_tdata !== reply_q[0].rgb || m_tuser !== reply_q[0].hit) begin
					fail_count++;
					if (fail_count <= 20)
						$display("%0t: mismatch: expected rgb %h valid %b, got rgb %h valid %b",
							$time, reply_q[0].rgb, reply_q[0].hit, m_tdata, m_tuser);
					void'(reply_q.pop_front());
				end else begin
					void'(reply_q.pop_front());
				end
			end
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_left <= $urandom_range(4, 60);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ~m_tready;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL framebuffer_rect_fill_palette_engine");
			$finish;
		end
	end

	initial begin
		dir_row_t  dir_rows [DIR_ROWS];
		draw_cmd_t c;
		fail_count     = 0;
		cycle_count    = 0;
		burst_left     = 0;
		big_fills_left = 2;
		n_fill = 0; n_outline = 0; n_read = 0; n_hit = 0; n_pal = 0;
		last_x = 0; last_y = 0; last_w = 1; last_h = 1; last_colour = 8'd0;
		for (int i = 0; i < fre_pkg::PIXELS; i++)
			shadow_fb[i] = 8'd0;
		for (int i = 0; i < fre_pkg::PAL_DEPTH; i++)
			shadow_pal[i] = (i < fre_pkg::CUBE_ENTRIES) ?
				rgb565_swapped(8'((i / 30) * 51), 8'(((i / 5) % 6) * 51),
				8'((i % 5) * 63)) : 16'h0000;

		dir_rows = '{
			'{cmd_of(fre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'h0000, 1'b1}},
			'{cmd_of(fre_pkg::OP_READ, 319, 239, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'h0000, 1'b1}},
			'{cmd_of(fre_pkg::OP_READ, -1, 0, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 320, 0, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 0, 240, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, -2048, -2048, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 2047, 2047, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_FILL, -2048, -2048, 2047, 2047, 255, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_FILL, 2047, 2047, 2047, 2047, 255, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_FILL, 10, 10, -2048, 5, 9, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_FILL, 10, 10, 5, 0, 9, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_FILL, -5, -5, 2047, 2047, 255, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'h0000, 1'b1}},
			'{cmd_of(fre_pkg::OP_PALETTE, 0, 0, 0, 0, 255, 255, 255, 255),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 319, 239, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'hFFFF, 1'b1}},
			'{cmd_of(fre_pkg::OP_PALETTE, 0, 0, 0, 0, 128, 248, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_FILL, 100, 100, 3, 2, 128, 0, 0, 0),
				1'b1, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 102, 101, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'h00F8, 1'b1}},
			'{cmd_of(fre_pkg::OP_READ, 103, 101, 0, 0, 0, 0, 0, 0),
				1'b1, '{16'hFFFF, 1'b1}},
			'{cmd_of(fre_pkg::OP_OUTLINE, 50, 60, -3, 4, 7, 0, 0, 0),
				1'b0, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 46, 62, 0, 0, 0, 0, 0, 0),
				1'b0, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_OUTLINE, 200, 20, 5, 0, 33, 0, 0, 0),
				1'b0, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 202, 19, 0, 0, 0, 0, 0, 0),
				1'b0, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_OUTLINE, 300, 220, 40, 40, 179, 0, 0, 0),
				1'b0, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 300, 230, 0, 0, 0, 0, 0, 0),
				1'b0, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_PALETTE, 0, 0, 0, 0, 7, 7, 3, 7),
				1'b0, '{16'h0000, 1'b0}},
			'{cmd_of(fre_pkg::OP_READ, 50, 61, 0, 0, 0, 0, 0, 0),
				1'b0, '{16'h0000, 1'b0}}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			put_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

		for (int i = 0; i < RAND_CMDS; i++) begin
			gen_random_cmd(c);
			put_cmd(c, 1'b0, '{16'h0000, 1'b0});
		end
		s_tvalid <= 1'b0;

		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d fills, %0d outlines and %0d palette writes after the power-up clear,",
			n_fill, n_outline, n_pal);
		$display("with %0d pixel reads (%0d on screen); %0d result errors.",
			n_read, n_hit, fail_count);
		if (fail_count == 0)
			$display("PASS framebuffer_rect_fill_palette_engine");
		else
			$display("FAIL framebuffer_rect_fill_palette_engine");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/fre_pkg.sv
hdl/fre_ctrl.sv
hdl/fre_datapath.sv
hdl/framebuffer_rect_fill_palette_engine.sv
tb/framebuffer_rect_fill_palette_engine_tb.sv
